// ===== hdl/owbm_pkg.sv =====
// Shared constants, phase codes and configuration indexes of the single-wire bus master.
`default_nettype none
package owbm_pkg;

  localparam int TIMER_BITS        = 10;
  localparam int LIM_W             = 10;
  localparam int CMP_W             = (TIMER_BITS > LIM_W) ? TIMER_BITS : LIM_W;
  localparam int WRITE0_RECOVER_US = 2;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_RESET = 2'd1;
  localparam cmd_t CMD_WRITE = 2'd2;
  localparam cmd_t CMD_READ  = 2'd3;

  typedef logic [3:0] phase_t;
  localparam phase_t PH_IDLE      = 4'd0;
  localparam phase_t PH_RST_LOW   = 4'd1;
  localparam phase_t PH_PRES_WAIT = 4'd2;
  localparam phase_t PH_PRES_LOW  = 4'd3;
  localparam phase_t PH_WR_LOW    = 4'd4;
  localparam phase_t PH_WR_REC    = 4'd5;
  localparam phase_t PH_RD_LOW    = 4'd6;
  localparam phase_t PH_RD_SAMPLE = 4'd7;
  localparam phase_t PH_RD_REC    = 4'd8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_RESET_LOW     = 4'd0;
  localparam cfg_idx_t REG_PRESENCE_WAIT = 4'd1;
  localparam cfg_idx_t REG_PRESENCE_MAX  = 4'd2;
  localparam cfg_idx_t REG_READ_LOW      = 4'd3;
  localparam cfg_idx_t REG_READ_RECOVER  = 4'd4;
  localparam cfg_idx_t REG_WRITE1_LOW    = 4'd5;
  localparam cfg_idx_t REG_WRITE1_RECOV  = 4'd6;
  localparam cfg_idx_t REG_WRITE0_LOW    = 4'd7;

  localparam logic [9:0] RST_RESET_LOW     = 10'd480;
  localparam logic [7:0] RST_PRESENCE_WAIT = 8'd100;
  localparam logic [9:0] RST_PRESENCE_MAX  = 10'd240;
  localparam logic [5:0] RST_READ_LOW      = 6'd10;
  localparam logic [7:0] RST_READ_RECOVER  = 8'd45;
  localparam logic [5:0] RST_WRITE1_LOW    = 6'd8;
  localparam logic [7:0] RST_WRITE1_RECOV  = 8'd58;
  localparam logic [7:0] RST_WRITE0_LOW    = 8'd70;

endpackage
`default_nettype wire

// ===== hdl/onewire_bus_master.sv =====
// Top level of the single-wire bus master: tick sequencer, timing registers and result register.
`default_nettype none
// Each input beat is one microsecond tick and yields exactly one result beat that says whether
// the bus is pulled low on that tick, plus busy, done, presence and received-byte status. A new
// tick is taken every clock cycle; the result register is the only stage, and the input is held
// off only while an untaken result sits in it. Timing registers are to be written through the
// cfg port only while no operation runs; the block does not enforce it. A limit of zero acts
// as one. Commands that arrive while busy are dropped and flagged as rejected on that tick.
module onewire_bus_master (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_cmd,
  input  wire logic [7:0]                          in_tx_byte,
  input  wire logic                                in_line_level,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_drive_low,
  output logic                                     out_busy_res,
  output logic                                     out_done_res,
  output logic                                     out_presence_ok,
  output logic [7:0]                               out_rx_byte,
  output logic                                     out_rejected,
  input  wire logic                                cfg_we,
  input  wire logic [owbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [owbm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int TB = owbm_pkg::TIMER_BITS;
  localparam int CW = owbm_pkg::CMP_W;
  localparam logic [TB-1:0] TMAX  = {TB{1'b1}};
  localparam logic [CW-1:0] TMAXC = CW'(TMAX);

  logic [9:0] reset_low_r, presence_max_r;
  logic [7:0] presence_wait_r, read_recover_r, write1_recover_r, write0_low_r;
  logic [5:0] read_low_r, write1_low_r;

  owbm_pkg::phase_t ph_r, ph_e, ph_nxt;
  logic [TB-1:0]    cnt_r, cnt_e, cnt_nxt, cnt_base, cnt_inc;
  logic [2:0]       bit_r, bit_e, bit_nxt;
  logic [7:0]       sh_r, sh_e, sh_nxt;
  logic             pres_r, pres_nxt;
  logic [7:0]       rx_r, rx_nxt;
  logic [owbm_pkg::LIM_W-1:0] lim;
  logic [CW-1:0]    lim_c;
  logic             hit, drive, done, rej;

  logic out_valid_r, out_drive_low_r, out_busy_r, out_done_r, out_pres_r, out_rej_r;
  logic [7:0] out_rx_r;
  logic in_fire;

  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r      <= owbm_pkg::RST_RESET_LOW;
      presence_wait_r  <= owbm_pkg::RST_PRESENCE_WAIT;
      presence_max_r   <= owbm_pkg::RST_PRESENCE_MAX;
      read_low_r       <= owbm_pkg::RST_READ_LOW;
      read_recover_r   <= owbm_pkg::RST_READ_RECOVER;
      write1_low_r     <= owbm_pkg::RST_WRITE1_LOW;
      write1_recover_r <= owbm_pkg::RST_WRITE1_RECOV;
      write0_low_r     <= owbm_pkg::RST_WRITE0_LOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        owbm_pkg::REG_RESET_LOW:     reset_low_r      <= cfg_wdata[9:0];
        owbm_pkg::REG_PRESENCE_WAIT: presence_wait_r  <= cfg_wdata[7:0];
        owbm_pkg::REG_PRESENCE_MAX:  presence_max_r   <= cfg_wdata[9:0];
        owbm_pkg::REG_READ_LOW:      read_low_r       <= cfg_wdata[5:0];
        owbm_pkg::REG_READ_RECOVER:  read_recover_r   <= cfg_wdata[7:0];
        owbm_pkg::REG_WRITE1_LOW:    write1_low_r     <= cfg_wdata[5:0];
        owbm_pkg::REG_WRITE1_RECOV:  write1_recover_r <= cfg_wdata[7:0];
        owbm_pkg::REG_WRITE0_LOW:    write0_low_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Command decode: an accepted command in idle starts its operation on this same tick.
  always_comb begin
    ph_e  = ph_r;
    cnt_e = cnt_r;
    bit_e = bit_r;
    sh_e  = sh_r;
    rej   = 1'b0;
    if (ph_r != owbm_pkg::PH_IDLE) begin
      rej = (in_cmd != owbm_pkg::CMD_TICK);
    end else begin
      unique case (in_cmd)
        owbm_pkg::CMD_RESET: begin
          ph_e  = owbm_pkg::PH_RST_LOW;
          cnt_e = '0;
        end
        owbm_pkg::CMD_WRITE: begin
          ph_e  = owbm_pkg::PH_WR_LOW;
          cnt_e = '0;
          bit_e = '0;
          sh_e  = in_tx_byte;
        end
        owbm_pkg::CMD_READ: begin
          ph_e  = owbm_pkg::PH_RD_LOW;
          cnt_e = '0;
          bit_e = '0;
          sh_e  = '0;
        end
        default: ;
      endcase
    end
  end

  // One shared saturating tick counter and limit compare.
  always_comb begin
    cnt_base = cnt_e;
    lim      = '0;
    unique case (ph_e)
      owbm_pkg::PH_RST_LOW:   lim = reset_low_r;
      owbm_pkg::PH_PRES_WAIT: begin
        if (in_line_level) begin
          lim = {2'b00, presence_wait_r};
        end else begin
          lim      = presence_max_r;
          cnt_base = '0;
        end
      end
      owbm_pkg::PH_PRES_LOW:  lim = presence_max_r;
      owbm_pkg::PH_WR_LOW:    lim = sh_e[0] ? {4'b0000, write1_low_r} : {2'b00, write0_low_r};
      owbm_pkg::PH_WR_REC:    lim = sh_e[0] ? {2'b00, write1_recover_r}
                                            : 10'(owbm_pkg::WRITE0_RECOVER_US);
      owbm_pkg::PH_RD_LOW:    lim = {4'b0000, read_low_r};
      owbm_pkg::PH_RD_REC:    lim = {2'b00, read_recover_r};
      default: ;
    endcase
    cnt_inc = (cnt_base == TMAX) ? cnt_base : cnt_base + 1'b1;
    lim_c   = (CW'(lim) > TMAXC) ? TMAXC : CW'(lim);
    hit     = CW'(cnt_inc) >= lim_c;
  end

  always_comb begin
    ph_nxt   = ph_e;
    cnt_nxt  = cnt_e;
    bit_nxt  = bit_e;
    sh_nxt   = sh_e;
    pres_nxt = pres_r;
    rx_nxt   = rx_r;
    drive    = 1'b0;
    done     = 1'b0;
    unique case (ph_e)
      owbm_pkg::PH_IDLE: ;
      owbm_pkg::PH_RST_LOW: begin
        drive   = 1'b1;
        cnt_nxt = hit ? '0 : cnt_inc;
        if (hit) begin
          ph_nxt = owbm_pkg::PH_PRES_WAIT;
        end
      end
      owbm_pkg::PH_PRES_WAIT: begin
        cnt_nxt = cnt_inc;
        if (!in_line_level) begin
          ph_nxt = owbm_pkg::PH_PRES_LOW;
        end
        if (hit) begin
          pres_nxt = 1'b0;
          done     = 1'b1;
          ph_nxt   = owbm_pkg::PH_IDLE;
        end
      end
      owbm_pkg::PH_PRES_LOW: begin
        if (in_line_level) begin
          pres_nxt = 1'b1;
          done     = 1'b1;
          ph_nxt   = owbm_pkg::PH_IDLE;
        end else begin
          cnt_nxt = cnt_inc;
          if (hit) begin
            pres_nxt = 1'b0;
            done     = 1'b1;
            ph_nxt   = owbm_pkg::PH_IDLE;
          end
        end
      end
      owbm_pkg::PH_WR_LOW: begin
        drive   = 1'b1;
        cnt_nxt = hit ? '0 : cnt_inc;
        if (hit) begin
          ph_nxt = owbm_pkg::PH_WR_REC;
        end
      end
      owbm_pkg::PH_WR_REC: begin
        cnt_nxt = hit ? '0 : cnt_inc;
        if (hit) begin
          sh_nxt = {1'b0, sh_e[7:1]};
          if (bit_e == 3'd7) begin
            bit_nxt = '0;
            done    = 1'b1;
            ph_nxt  = owbm_pkg::PH_IDLE;
          end else begin
            bit_nxt = bit_e + 1'b1;
            ph_nxt  = owbm_pkg::PH_WR_LOW;
          end
        end
      end
      owbm_pkg::PH_RD_LOW: begin
        drive   = 1'b1;
        cnt_nxt = hit ? '0 : cnt_inc;
        if (hit) begin
          ph_nxt = owbm_pkg::PH_RD_SAMPLE;
        end
      end
      owbm_pkg::PH_RD_SAMPLE: begin
        sh_nxt  = sh_e | ({7'd0, in_line_level} << bit_e);
        ph_nxt  = owbm_pkg::PH_RD_REC;
        cnt_nxt = '0;
      end
      owbm_pkg::PH_RD_REC: begin
        cnt_nxt = hit ? '0 : cnt_inc;
        if (hit) begin
          if (bit_e == 3'd7) begin
            rx_nxt  = sh_e;
            bit_nxt = '0;
            done    = 1'b1;
            ph_nxt  = owbm_pkg::PH_IDLE;
          end else begin
            bit_nxt = bit_e + 1'b1;
            ph_nxt  = owbm_pkg::PH_RD_LOW;
          end
        end
      end
      default: ph_nxt = owbm_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= owbm_pkg::PH_IDLE;
      cnt_r       <= '0;
      bit_r       <= '0;
      sh_r        <= '0;
      pres_r      <= 1'b0;
      rx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        ph_r   <= ph_nxt;
        cnt_r  <= cnt_nxt;
        bit_r  <= bit_nxt;
        sh_r   <= sh_nxt;
        pres_r <= pres_nxt;
        rx_r   <= rx_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_drive_low_r <= drive;
      out_busy_r      <= (ph_nxt != owbm_pkg::PH_IDLE);
      out_done_r      <= done;
      out_pres_r      <= pres_nxt;
      out_rx_r        <= rx_nxt;
      out_rej_r       <= rej;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_low   = out_drive_low_r;
  assign out_busy_res    = out_busy_r;
  assign out_done_res    = out_done_r;
  assign out_presence_ok = out_pres_r;
  assign out_rx_byte     = out_rx_r;
  assign out_rejected    = out_rej_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done beat still reports busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_low |-> out_busy_res)
    else $error("line driven low while no operation runs");

  a_idle_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == owbm_pkg::PH_IDLE |-> bit_r == 3'd0)
    else $error("bit index not cleared in idle");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_busy_res == (ph_r != owbm_pkg::PH_IDLE) && out_presence_ok == pres_r)
    else $error("result beat disagrees with sequencer state");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the single-wire bus master: a tick-level predictor and a bus responder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic       presence_ok;
    logic [7:0] rx_byte;
    logic       rejected;
  } tick_res_t;

  localparam int unsigned TICK_MAX    = (1 << owbm_pkg::TIMER_BITS) - 1;
  localparam int          HOLD_CYCLES = 120;
  localparam int          DRAIN_LIMIT = 400;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  owbm_pkg::cmd_t                  in_cmd = owbm_pkg::CMD_TICK;
  logic [7:0]                      in_tx_byte = 8'h00;
  logic                            in_line_level = 1'b1;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_drive_low;
  logic                            out_busy_res;
  logic                            out_done_res;
  logic                            out_presence_ok;
  logic [7:0]                      out_rx_byte;
  logic                            out_rejected;
  logic                            cfg_we = 1'b0;
  owbm_pkg::cfg_idx_t              cfg_index = owbm_pkg::REG_RESET_LOW;
  logic [owbm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  onewire_bus_master DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_tx_byte      (in_tx_byte),
    .in_line_level   (in_line_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_drive_low   (out_drive_low),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_presence_ok (out_presence_ok),
    .out_rx_byte     (out_rx_byte),
    .out_rejected    (out_rejected),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #6 clk = ~clk;

  int unsigned       cfg_val [8];
  owbm_pkg::phase_t  ph;
  int unsigned       tcnt;
  int unsigned       bidx;
  logic [7:0]        shreg;
  logic              pres_flag;
  logic [7:0]        rx_last;

  tick_res_t   expected_q [$];
  int          mismatches = 0;

  bit          steady = 1'b0;
  bit          hold_output = 1'b0;
  bit          keep_plan = 1'b0;
  bit          noise_line = 1'b0;
  int          pres_delay = 0;
  int          pres_len = 1;
  int          high_seen = 0;
  int          low_seen = 0;
  logic [7:0]  rd_plan = 8'h00;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit timer_hit(int unsigned lim);
    int unsigned clipped;
    clipped = (lim > TICK_MAX) ? TICK_MAX : lim;
    if (tcnt < TICK_MAX) tcnt++;
    return tcnt >= clipped;
  endfunction

  function automatic tick_res_t bus_master_step(owbm_pkg::cmd_t c, logic [7:0] b, logic l);
    tick_res_t r;
    r = '0;
    if (ph != owbm_pkg::PH_IDLE) begin
      if (c != owbm_pkg::CMD_TICK) r.rejected = 1'b1;
    end else if (c == owbm_pkg::CMD_RESET) begin
      ph = owbm_pkg::PH_RST_LOW; tcnt = 0;
    end else if (c == owbm_pkg::CMD_WRITE) begin
      ph = owbm_pkg::PH_WR_LOW; tcnt = 0; bidx = 0; shreg = b;
    end else if (c == owbm_pkg::CMD_READ) begin
      ph = owbm_pkg::PH_RD_LOW; tcnt = 0; bidx = 0; shreg = 8'h00;
    end
    case (ph)
      owbm_pkg::PH_IDLE: ;
      owbm_pkg::PH_RST_LOW: begin
        r.drive_low = 1'b1;
        if (timer_hit(cfg_val[owbm_pkg::REG_RESET_LOW])) begin
          ph = owbm_pkg::PH_PRES_WAIT; tcnt = 0;
        end
      end
      owbm_pkg::PH_PRES_WAIT: begin
        if (l) begin
          if (timer_hit(cfg_val[owbm_pkg::REG_PRESENCE_WAIT])) begin
            pres_flag = 1'b0; r.done = 1'b1; ph = owbm_pkg::PH_IDLE;
          end
        end else begin
          ph = owbm_pkg::PH_PRES_LOW; tcnt = 0;
          if (timer_hit(cfg_val[owbm_pkg::REG_PRESENCE_MAX])) begin
            pres_flag = 1'b0; r.done = 1'b1; ph = owbm_pkg::PH_IDLE;
          end
        end
      end
      owbm_pkg::PH_PRES_LOW: begin
        if (l) begin
          pres_flag = 1'b1; r.done = 1'b1; ph = owbm_pkg::PH_IDLE;
        end else if (timer_hit(cfg_val[owbm_pkg::REG_PRESENCE_MAX])) begin
          pres_flag = 1'b0; r.done = 1'b1; ph = owbm_pkg::PH_IDLE;
        end
      end
      owbm_pkg::PH_WR_LOW: begin
        r.drive_low = 1'b1;
        if (timer_hit(shreg[0] ? cfg_val[owbm_pkg::REG_WRITE1_LOW]
                               : cfg_val[owbm_pkg::REG_WRITE0_LOW])) begin
          ph = owbm_pkg::PH_WR_REC; tcnt = 0;
        end
      end
      owbm_pkg::PH_WR_REC: begin
        if (timer_hit(shreg[0] ? cfg_val[owbm_pkg::REG_WRITE1_RECOV]
                               : owbm_pkg::WRITE0_RECOVER_US)) begin
          shreg = shreg >> 1;
          tcnt = 0;
          if (bidx >= 7) begin
            bidx = 0; r.done = 1'b1; ph = owbm_pkg::PH_IDLE;
          end else begin
            bidx++; ph = owbm_pkg::PH_WR_LOW;
          end
        end
      end
      owbm_pkg::PH_RD_LOW: begin
        r.drive_low = 1'b1;
        if (timer_hit(cfg_val[owbm_pkg::REG_READ_LOW])) begin
          ph = owbm_pkg::PH_RD_SAMPLE; tcnt = 0;
        end
      end
      owbm_pkg::PH_RD_SAMPLE: begin
        shreg = shreg | (8'(l) << bidx[2:0]);
        ph = owbm_pkg::PH_RD_REC; tcnt = 0;
      end
      owbm_pkg::PH_RD_REC: begin
        if (timer_hit(cfg_val[owbm_pkg::REG_READ_RECOVER])) begin
          tcnt = 0;
          if (bidx >= 7) begin
            rx_last = shreg; bidx = 0; r.done = 1'b1; ph = owbm_pkg::PH_IDLE;
          end else begin
            bidx++; ph = owbm_pkg::PH_RD_LOW;
          end
        end
      end
      default: ph = owbm_pkg::PH_IDLE;
    endcase
    r.busy        = (ph != owbm_pkg::PH_IDLE);
    r.presence_ok = pres_flag;
    r.rx_byte     = rx_last;
    return r;
  endfunction

  function automatic bit ends_on(owbm_pkg::cmd_t c, logic [7:0] b, logic l);
    owbm_pkg::phase_t s_ph;
    int unsigned      s_tcnt;
    int unsigned      s_bidx;
    logic [7:0]       s_shreg;
    logic             s_pres;
    logic [7:0]       s_rx;
    tick_res_t        r;
    s_ph = ph; s_tcnt = tcnt; s_bidx = bidx; s_shreg = shreg; s_pres = pres_flag; s_rx = rx_last;
    r = bus_master_step(c, b, l);
    ph = s_ph; tcnt = s_tcnt; bidx = s_bidx; shreg = s_shreg; pres_flag = s_pres; rx_last = s_rx;
    return r.done;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_beats
    tick_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing expected", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_drive_low !== want.drive_low)
          report_mismatch("drive_low", out_drive_low, want.drive_low);
        if (out_busy_res !== want.busy)
          report_mismatch("busy_res", out_busy_res, want.busy);
        if (out_done_res !== want.done)
          report_mismatch("done_res", out_done_res, want.done);
        if (out_presence_ok !== want.presence_ok)
          report_mismatch("presence_ok", out_presence_ok, want.presence_ok);
        if (out_rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", out_rx_byte, want.rx_byte);
        if (out_rejected !== want.rejected)
          report_mismatch("rejected", out_rejected, want.rejected);
      end
    end
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end else begin
        gap = steady ? 0 : pick_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic send_item(owbm_pkg::cmd_t c, logic [7:0] b, logic l);
    int gap;
    gap = steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_tx_byte    <= b;
    in_line_level <= l;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(bus_master_step(c, b, l));
  endtask

  // The line level plays the part of a device on the bus for the tick that is about to run.
  task automatic bus_tick(owbm_pkg::cmd_t c, logic [7:0] b);
    logic l;
    if (ph == owbm_pkg::PH_IDLE && c != owbm_pkg::CMD_TICK) begin
      high_seen = 0;
      low_seen  = 0;
      if (!keep_plan) begin
        pres_delay = $urandom_range(0, cfg_val[owbm_pkg::REG_PRESENCE_WAIT] + 1);
        pres_len   = $urandom_range(1, cfg_val[owbm_pkg::REG_PRESENCE_MAX] + 1);
        rd_plan    = 8'($urandom);
        noise_line = ($urandom_range(0, 9) == 0);
      end
    end
    if (noise_line) begin
      l = 1'($urandom_range(0, 1));
    end else begin
      case (ph)
        owbm_pkg::PH_PRES_WAIT, owbm_pkg::PH_PRES_LOW: begin
          if (high_seen < pres_delay) begin
            l = 1'b1; high_seen++;
          end else if (low_seen < pres_len) begin
            l = 1'b0; low_seen++;
          end else begin
            l = 1'b1;
          end
        end
        owbm_pkg::PH_RD_SAMPLE: l = rd_plan[bidx[2:0]];
        default: l = 1'($urandom_range(0, 1));
      endcase
    end
    send_item(c, b, l);
  endtask

  task automatic run_op(owbm_pkg::cmd_t c, logic [7:0] b, bit jam);
    bus_tick(c, b);
    while (ph != owbm_pkg::PH_IDLE)
      bus_tick((jam && $urandom_range(0, 3) == 0) ? owbm_pkg::cmd_t'($urandom_range(1, 3))
                                                  : owbm_pkg::CMD_TICK,
               8'($urandom));
  endtask

  task automatic run_reset(int delay, int len);
    keep_plan  = 1'b1;
    noise_line = 1'b0;
    pres_delay = delay;
    pres_len   = len;
    run_op(owbm_pkg::CMD_RESET, 8'($urandom), 1'b0);
    keep_plan  = 1'b0;
  endtask

  task automatic run_read(logic [7:0] pattern);
    keep_plan  = 1'b1;
    noise_line = 1'b0;
    rd_plan    = pattern;
    run_op(owbm_pkg::CMD_READ, 8'($urandom), 1'b0);
    keep_plan  = 1'b0;
  endtask

  task automatic quiesce();
    int waited;
    while (ph != owbm_pkg::PH_IDLE) bus_tick(owbm_pkg::CMD_TICK, 8'($urandom));
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_q.size() != 0) begin
      report_mismatch("result beats never delivered", 0, expected_q.size());
      expected_q.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timing_reg(owbm_pkg::cfg_idx_t idx,
                                  logic [owbm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      owbm_pkg::REG_RESET_LOW, owbm_pkg::REG_PRESENCE_MAX: cfg_val[idx] = val & 10'h3FF;
      owbm_pkg::REG_READ_LOW, owbm_pkg::REG_WRITE1_LOW:    cfg_val[idx] = val & 10'h03F;
      default:                                             cfg_val[idx] = val & 10'h0FF;
    endcase
  endtask

  task automatic set_timing(logic [9:0] rst_low, logic [9:0] pres_wait, logic [9:0] pres_max,
                            logic [9:0] rd_low, logic [9:0] rd_rec, logic [9:0] w1_low,
                            logic [9:0] w1_rec, logic [9:0] w0_low);
    quiesce();
    write_timing_reg(owbm_pkg::REG_RESET_LOW, rst_low);
    write_timing_reg(owbm_pkg::REG_PRESENCE_WAIT, pres_wait);
    write_timing_reg(owbm_pkg::REG_PRESENCE_MAX, pres_max);
    write_timing_reg(owbm_pkg::REG_READ_LOW, rd_low);
    write_timing_reg(owbm_pkg::REG_READ_RECOVER, rd_rec);
    write_timing_reg(owbm_pkg::REG_WRITE1_LOW, w1_low);
    write_timing_reg(owbm_pkg::REG_WRITE1_RECOV, w1_rec);
    write_timing_reg(owbm_pkg::REG_WRITE0_LOW, w0_low);
    repeat (2) @(posedge clk);
  endtask

  task automatic test_default_timing();
    bus_tick(owbm_pkg::CMD_TICK, 8'h00);
    bus_tick(owbm_pkg::CMD_TICK, 8'hFF);
    run_reset(3, 2);
    quiesce();
  endtask

  task automatic test_presence_cases();
    set_timing(3, 4, 5, 2, 2, 2, 2, 3);
    run_reset(0, 2);
    run_reset(3, 1);
    run_reset(4, 1);
    run_reset(1, 5);
    run_reset(2, 4);
    quiesce();
    write_timing_reg(owbm_pkg::REG_PRESENCE_MAX, 1);
    run_reset(0, 1);
    run_reset(2, 3);
    quiesce();
  endtask

  task automatic test_byte_transfers();
    set_timing(2, 3, 3, 2, 2, 2, 3, 2);
    run_op(owbm_pkg::CMD_WRITE, 8'h00, 1'b0);
    run_op(owbm_pkg::CMD_WRITE, 8'hFF, 1'b0);
    run_op(owbm_pkg::CMD_WRITE, 8'h01, 1'b0);
    run_op(owbm_pkg::CMD_WRITE, 8'h80, 1'b0);
    run_read(8'h00);
    run_read(8'hFF);
    run_read(8'h96);
    quiesce();
  endtask

  task automatic test_busy_rejection();
    owbm_pkg::cmd_t c;
    set_timing(2, 3, 3, 2, 2, 2, 3, 2);
    bus_tick(owbm_pkg::CMD_WRITE, 8'h3C);
    while (ph != owbm_pkg::PH_IDLE) begin
      if (ends_on(owbm_pkg::CMD_WRITE, 8'h00, 1'b1)) c = owbm_pkg::CMD_WRITE;
      else c = ($urandom_range(0, 2) == 0) ? owbm_pkg::cmd_t'($urandom_range(1, 3))
                                           : owbm_pkg::CMD_TICK;
      bus_tick(c, 8'($urandom));
    end
    steady = 1'b1;
    bus_tick(owbm_pkg::CMD_READ, 8'h00);
    while (ph != owbm_pkg::PH_IDLE) begin
      if (ends_on(owbm_pkg::CMD_RESET, 8'h00, 1'b1)) c = owbm_pkg::CMD_RESET;
      else c = ($urandom_range(0, 2) == 0) ? owbm_pkg::cmd_t'($urandom_range(1, 3))
                                           : owbm_pkg::CMD_TICK;
      bus_tick(c, 8'($urandom));
    end
    steady = 1'b0;
    run_op(owbm_pkg::CMD_RESET, 8'h00, 1'b1);
    quiesce();
  endtask

  task automatic test_zero_limits();
    set_timing(0, 0, 0, 0, 0, 0, 0, 0);
    run_reset(0, 2);
    run_reset(1, 1);
    run_op(owbm_pkg::CMD_WRITE, 8'hA5, 1'b0);
    run_read(8'h69);
    quiesce();
  endtask

  // Upper data bits beyond each register's width must be dropped.
  task automatic test_register_extremes();
    set_timing(10'h002, 10'h3FF, 10'h3FF, 10'h3C2, 10'h302, 10'h3C2, 10'h303, 10'h302);
    run_reset(10, 40);
    run_op(owbm_pkg::CMD_WRITE, 8'hA5, 1'b0);
    run_read(8'h5A);
    quiesce();
  endtask

  task automatic test_output_stall();
    set_timing(2, 3, 4, 2, 3, 2, 2, 3);
    steady      = 1'b1;
    hold_output = 1'b1;
    run_op(owbm_pkg::CMD_WRITE, 8'hC6, 1'b1);
    steady      = 1'b0;
    quiesce();
  endtask

  task automatic test_random_traffic();
    owbm_pkg::cmd_t c;
    int             n;
    for (int k = 0; k < 4; k++) begin
      if (k == 0) begin
        set_timing(1, 1, 1, 1, 1, 1, 1, 1);
      end else begin
        set_timing(($urandom_range(0, 7) == 0) ? 10'($urandom_range(6, 40))
                                               : 10'($urandom_range(0, 5)),
                   10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)),
                   10'($urandom_range(0, 5)), 10'($urandom_range(0, 5)),
                   10'($urandom_range(0, 5)),
                   ($urandom_range(0, 7) == 0) ? 10'($urandom_range(6, 30))
                                               : 10'($urandom_range(0, 5)),
                   10'($urandom_range(0, 6)));
      end
      steady = (k == 3);
      n = 0;
      while (n < 65) begin
        if (ph == owbm_pkg::PH_IDLE)
          c = ($urandom_range(0, 3) == 0) ? owbm_pkg::CMD_TICK
                                          : owbm_pkg::cmd_t'($urandom_range(1, 3));
        else
          c = ($urandom_range(0, 6) == 0) ? owbm_pkg::cmd_t'($urandom_range(1, 3))
                                          : owbm_pkg::CMD_TICK;
        bus_tick(c, 8'($urandom));
        n++;
      end
      steady = 1'b0;
    end
    quiesce();
  endtask

  initial begin
    cfg_val[owbm_pkg::REG_RESET_LOW]     = owbm_pkg::RST_RESET_LOW;
    cfg_val[owbm_pkg::REG_PRESENCE_WAIT] = owbm_pkg::RST_PRESENCE_WAIT;
    cfg_val[owbm_pkg::REG_PRESENCE_MAX]  = owbm_pkg::RST_PRESENCE_MAX;
    cfg_val[owbm_pkg::REG_READ_LOW]      = owbm_pkg::RST_READ_LOW;
    cfg_val[owbm_pkg::REG_READ_RECOVER]  = owbm_pkg::RST_READ_RECOVER;
    cfg_val[owbm_pkg::REG_WRITE1_LOW]    = owbm_pkg::RST_WRITE1_LOW;
    cfg_val[owbm_pkg::REG_WRITE1_RECOV]  = owbm_pkg::RST_WRITE1_RECOV;
    cfg_val[owbm_pkg::REG_WRITE0_LOW]    = owbm_pkg::RST_WRITE0_LOW;
    ph = owbm_pkg::PH_IDLE; tcnt = 0; bidx = 0; shreg = 8'h00; pres_flag = 1'b0;
    rx_last = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_timing();
    test_presence_cases();
    test_byte_transfers();
    test_busy_rejection();
    test_zero_limits();
    test_register_extremes();
    test_output_stall();
    test_random_traffic();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
